// ===== hdl/rfq_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, codes and memory word types of the run queue.
// Used by the run queue core and its link memory instances.
package rfq_pkg;
  localparam int ThreadSlots    = 64;
  localparam int PriorityLevels = 256;
  localparam int ThrW           = $clog2(ThreadSlots);
  localparam int LvlW           = $clog2(PriorityLevels);
  localparam int GrpW           = 16;
  localparam int NumGrp         = (PriorityLevels + GrpW - 1) / GrpW;
  localparam int GrpIdxW        = (NumGrp > 1) ? $clog2(NumGrp) : 1;
  localparam int SubW           = $clog2(GrpW);
  localparam int OccW           = NumGrp * GrpW;

  localparam logic [1:0] OpAdd     = 2'd0;
  localparam logic [1:0] OpRemove  = 2'd1;
  localparam logic [1:0] OpPeek    = 2'd2;

  localparam logic [1:0] StDone    = 2'd0;
  localparam logic [1:0] StAddDup  = 2'd1;
  localparam logic [1:0] StRemMiss = 2'd2;

  typedef struct packed {
    logic [LvlW-1:0] lvl;
    logic [ThrW-1:0] next;
    logic [ThrW-1:0] prev;
  } entry_t;

  typedef struct packed {
    logic [ThrW-1:0] first;
    logic [ThrW-1:0] last;
  } level_t;
endpackage

// ===== hdl/rfq_ram.sv =====
`timescale 1ns / 1ps
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
module rfq_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

// ===== hdl/priority_fifo_run_queue_core.sv =====
`timescale 1ns / 1ps
// Top level of the run queue: sequencer, link memories and head search.
// Depends on rfq_pkg and rfq_ram.
//
// The input channel carries one word per operation: add a thread at a
// priority, remove a thread, or peek. The output channel returns one word per
// operation with the current head thread, its priority, a nonempty flag and a
// status. Lower priority values are served first, and threads of equal
// priority leave in arrival order.
// An add or a remove first makes dependent read-modify-write accesses to
// the entry link memory and the level memory; every operation, a peek or a
// rejected request as well, then ends with a two-step search over the level
// bitmap and a read of the head level.
// One operation is in flight at a time; a new word is taken while the
// previous result still waits in the output register.
// If the receiver stalls, the finished result is held until the output
// register frees. Reset empties the queue by clearing the queued and level
// occupancy bits; the memories need no clearing pass.
module priority_fifo_run_queue_core
  import rfq_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] opcode_i,
  input  logic [5:0] thread_id_i,
  input  logic [7:0] priority_req_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       head_valid_o,
  output logic [5:0] head_thread_o,
  output logic [7:0] head_priority_o,
  output logic [1:0] status_o
);
  typedef enum logic [3:0] {
    S_IDLE, S_ADD1, S_ADD2, S_REM1, S_REM2, S_REM3, S_REM4, S_HEAD1, S_HEAD2, S_HEAD3
  } state_e;

  state_e              state_q;
  logic [ThrW-1:0]     thr_q, nx_q, pv_q;
  logic [LvlW-1:0]     lvl_q, hp_q;
  logic                last_flag_q;
  logic [1:0]          status_q;
  logic [ThreadSlots-1:0] queued_q;
  logic [OccW-1:0]     occ_q;
  logic [GrpIdxW-1:0]  grp_q;
  logic                grp_any_q;
  logic [GrpW-1:0]     slice_q;
  logic                out_valid_q, head_valid_q;
  logic [5:0]          head_thread_q;
  logic [7:0]          head_priority_q;
  logic [1:0]          out_status_q;

  logic                ent_we, ent_re, lvl_we, lvl_re;
  logic [ThrW-1:0]     ent_waddr, ent_raddr;
  logic [LvlW-1:0]     lvl_waddr, lvl_raddr;
  entry_t              ent_wdata, ent_rdata;
  level_t              lvl_wdata, lvl_rdata;

  logic                accept, is_first, is_last, occ_hit, out_free;
  logic [ThrW-1:0]     tid;
  logic [LvlW-1:0]     pri_lvl, head_lvl;
  logic [GrpIdxW-1:0]  grp_sel;
  logic                grp_any;
  logic [SubW-1:0]     sub_sel;

  rfq_ram #(.Width($bits(entry_t)), .Depth(ThreadSlots)) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ent_we),
    .waddr_i (ent_waddr),
    .wdata_i (ent_wdata),
    .re_i    (ent_re),
    .raddr_i (ent_raddr),
    .rdata_o (ent_rdata)
  );

  rfq_ram #(.Width($bits(level_t)), .Depth(PriorityLevels)) u_level_ram (
    .clk_i   (clk_i),
    .we_i    (lvl_we),
    .waddr_i (lvl_waddr),
    .wdata_i (lvl_wdata),
    .re_i    (lvl_re),
    .raddr_i (lvl_raddr),
    .rdata_o (lvl_rdata)
  );

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign tid        = ThrW'(thread_id_i);
  assign pri_lvl    = ({1'b0, priority_req_i} >= 9'(PriorityLevels)) ?
                      LvlW'(PriorityLevels - 1) : LvlW'(priority_req_i);
  assign is_first   = (lvl_rdata.first == thr_q);
  assign is_last    = (lvl_rdata.last == thr_q);
  assign occ_hit    = occ_q[lvl_q];
  assign out_free   = !out_valid_q || out_ready_i;
  assign head_lvl   = LvlW'(int'(grp_q) * GrpW + int'(sub_sel));

  always_comb begin
    grp_sel = '0;
    grp_any = 1'b0;
    for (int g = NumGrp - 1; g >= 0; g--) begin
      if (|occ_q[g*GrpW +: GrpW]) begin
        grp_sel = GrpIdxW'(g);
        grp_any = 1'b1;
      end
    end
  end

  always_comb begin
    sub_sel = '0;
    for (int i = GrpW - 1; i >= 0; i--) begin
      if (slice_q[i]) begin
        sub_sel = SubW'(i);
      end
    end
  end

  always_comb begin
    ent_we    = 1'b0;
    ent_waddr = thr_q;
    ent_wdata = '0;
    ent_re    = 1'b0;
    ent_raddr = thr_q;
    lvl_we    = 1'b0;
    lvl_waddr = lvl_q;
    lvl_wdata = '0;
    lvl_re    = 1'b0;
    lvl_raddr = lvl_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept && opcode_i == OpAdd && !queued_q[tid]) begin
          lvl_re    = 1'b1;
          lvl_raddr = pri_lvl;
        end else if (accept && opcode_i == OpRemove && queued_q[tid]) begin
          ent_re    = 1'b1;
          ent_raddr = tid;
        end
      end
      S_ADD1: begin
        ent_we    = 1'b1;
        ent_wdata = '{lvl: lvl_q, next: '0, prev: occ_hit ? lvl_rdata.last : '0};
        lvl_we    = 1'b1;
        lvl_wdata = '{first: occ_hit ? lvl_rdata.first : thr_q, last: thr_q};
        ent_re    = occ_hit;
        ent_raddr = lvl_rdata.last;
      end
      S_ADD2: begin
        ent_we    = 1'b1;
        ent_waddr = pv_q;
        ent_wdata = '{lvl: ent_rdata.lvl, next: thr_q, prev: ent_rdata.prev};
      end
      S_REM1: begin
        lvl_re    = 1'b1;
        lvl_raddr = ent_rdata.lvl;
      end
      S_REM2: begin
        if (!(is_first && is_last)) begin
          lvl_we    = 1'b1;
          lvl_wdata = '{first: is_first ? nx_q : lvl_rdata.first,
                        last:  is_last ? pv_q : lvl_rdata.last};
          ent_re    = 1'b1;
          ent_raddr = is_first ? nx_q : pv_q;
        end
      end
      S_REM3: begin
        ent_we    = 1'b1;
        ent_waddr = pv_q;
        ent_wdata = '{lvl: ent_rdata.lvl, next: nx_q, prev: ent_rdata.prev};
        ent_re    = !last_flag_q;
        ent_raddr = nx_q;
      end
      S_REM4: begin
        ent_we    = 1'b1;
        ent_waddr = nx_q;
        ent_wdata = '{lvl: ent_rdata.lvl, next: ent_rdata.next, prev: pv_q};
      end
      S_HEAD2: begin
        lvl_re    = grp_any_q;
        lvl_raddr = head_lvl;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      queued_q    <= '0;
      occ_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            thr_q    <= tid;
            lvl_q    <= pri_lvl;
            status_q <= StDone;
            state_q  <= S_HEAD1;
            if (opcode_i == OpAdd) begin
              if (queued_q[tid]) begin
                status_q <= StAddDup;
              end else begin
                state_q <= S_ADD1;
              end
            end else if (opcode_i == OpRemove) begin
              if (!queued_q[tid]) begin
                status_q <= StRemMiss;
              end else begin
                state_q <= S_REM1;
              end
            end
          end
        end
        S_ADD1: begin
          queued_q[thr_q] <= 1'b1;
          occ_q[lvl_q]    <= 1'b1;
          pv_q            <= lvl_rdata.last;
          state_q         <= occ_hit ? S_ADD2 : S_HEAD1;
        end
        S_ADD2: state_q <= S_HEAD1;
        S_REM1: begin
          lvl_q   <= ent_rdata.lvl;
          nx_q    <= ent_rdata.next;
          pv_q    <= ent_rdata.prev;
          state_q <= S_REM2;
        end
        S_REM2: begin
          queued_q[thr_q] <= 1'b0;
          last_flag_q     <= is_last;
          if (is_first && is_last) begin
            occ_q[lvl_q] <= 1'b0;
            state_q      <= S_HEAD1;
          end else if (!is_first) begin
            state_q <= S_REM3;
          end else begin
            state_q <= S_REM4;
          end
        end
        S_REM3: state_q <= last_flag_q ? S_HEAD1 : S_REM4;
        S_REM4: state_q <= S_HEAD1;
        S_HEAD1: begin
          grp_q     <= grp_sel;
          grp_any_q <= grp_any;
          slice_q   <= occ_q[int'(grp_sel)*GrpW +: GrpW];
          state_q   <= S_HEAD2;
        end
        S_HEAD2: begin
          hp_q    <= grp_any_q ? head_lvl : '0;
          state_q <= S_HEAD3;
        end
        S_HEAD3: begin
          if (out_free) begin
            out_valid_q     <= 1'b1;
            head_valid_q    <= grp_any_q;
            head_thread_q   <= grp_any_q ? 6'(lvl_rdata.first) : '0;
            head_priority_q <= 8'(hp_q);
            out_status_q    <= status_q;
            state_q         <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign head_valid_o    = head_valid_q;
  assign head_thread_o   = head_thread_q;
  assign head_priority_o = head_priority_q;
  assign status_o        = out_status_q;

  a_empty_fields : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !head_valid_o |-> head_thread_o == '0 && head_priority_o == '0)
    else $error("Empty queue result carries a nonzero head.");

  a_occ_implies_queued : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(queued_q) >= $countones(occ_q))
    else $error("More occupied levels than queued threads.");

  a_dup_not_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == StAddDup |-> head_valid_o)
    else $error("Duplicate add reported on an empty queue.");

  a_hold_stalled : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_HEAD3 && out_valid_q && !out_ready_i |=> state_q == S_HEAD3)
    else $error("Result overwrote a stalled output word.");
endmodule
